// ----- design/ion_trap_electric_field_sum_core_macros.svh -----
// Assertion macros shared by the field sum design.
`ifndef ION_TRAP_ELECTRIC_FIELD_SUM_CORE_MACROS_SVH
`define ION_TRAP_ELECTRIC_FIELD_SUM_CORE_MACROS_SVH
// Checks an implication under synchronous reset.
`define ITF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Checks an implication on the next cycle under synchronous reset.
`define ITF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/itf_pkg.sv -----
// Package with payload types, register indexes and constants for the field sum.
package itf_pkg;
  localparam int COS_FRAC_BITS_DEF = 30;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int NUM_REGS = 8;
  localparam int DIV_STEPS = 49;

  typedef enum logic [2:0] {
    REG_AXIAL_DC = 3'd0, REG_QUAD_OFF = 3'd1, REG_RF_AMP = 3'd2, REG_RF_RATE = 3'd3,
    REG_AC_AMP = 3'd4, REG_AC_RATE = 3'd5, REG_RADIUS = 3'd6, REG_LENGTH = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [47:0] time_tick;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] field_x;
    logic signed [47:0] field_y;
    logic signed [47:0] field_z;
    logic overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] axial_dc_voltage;
    logic signed [31:0] quad_dc_offset;
    logic signed [31:0] rf_amplitude;
    logic [31:0] rf_phase_rate;
    logic signed [31:0] ac_amplitude;
    logic [31:0] ac_phase_rate;
    logic [31:0] trap_radius;
    logic [31:0] axial_length;
  } cfg_t;

  function automatic logic [31:0] atan_turn(input int k);
    case (k)
      0: return 32'd536870912;  1: return 32'd316933406; 2: return 32'd167458907;
      3: return 32'd85004756;   4: return 32'd42667331;  5: return 32'd21354465;
      6: return 32'd10679838;   7: return 32'd5340245;   8: return 32'd2670163;
      9: return 32'd1335087;    10: return 32'd667544;   11: return 32'd333772;
      12: return 32'd166886;    13: return 32'd83443;    14: return 32'd41722;
      15: return 32'd20861;     16: return 32'd10430;    17: return 32'd5215;
      18: return 32'd2608;      19: return 32'd1304;     20: return 32'd652;
      21: return 32'd326;       22: return 32'd163;      23: return 32'd81;
      24: return 32'd41;        25: return 32'd20;       26: return 32'd10;
      27: return 32'd5;         28: return 32'd3;        29: return 32'd1;
      30: return 32'd1;         default: return 32'd0;
    endcase
  endfunction
endpackage

// ----- design/itf_cordic.sv -----
// Pipelined CORDIC cosine with a stall-aware enable, one step per stage.
module itf_cordic import itf_pkg::*; #(
  parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic en,
  input  logic [31:0] phase,
  output logic signed [COS_FRAC_BITS+1:0] cos_val
);
  // x and y stay within about 2^32; 36 bits hold them signed.
  logic signed [35:0] xs [CORDIC_STEPS+1];
  logic signed [35:0] ys [CORDIC_STEPS+1];
  logic signed [33:0] zs [CORDIC_STEPS+1];
  logic flips [CORDIC_STEPS+1];
  logic signed [33:0] z0;

  always_comb begin
    z0 = 34'(signed'(phase));
    xs[0] = 36'sd2608131496;
    ys[0] = '0;
    flips[0] = 1'b0;
    if (z0 > 34'sd1073741824) begin
      z0 = z0 - 34'sd2147483648;
      flips[0] = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      z0 = z0 + 34'sd2147483648;
      flips[0] = 1'b1;
    end
    zs[0] = z0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam int K = i % 32;
    always_ff @(posedge clk) begin
      if (en) begin
        flips[i+1] <= flips[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> K);
          ys[i+1] <= ys[i] + (xs[i] >>> K);
          zs[i+1] <= zs[i] - 34'(atan_turn(K));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> K);
          ys[i+1] <= ys[i] - (xs[i] >>> K);
          zs[i+1] <= zs[i] + 34'(atan_turn(K));
        end
      end
    end
  end

  // The clamped cosine reaches +1.0 exactly, so it needs two integer bits.
  logic signed [35:0] c;
  localparam logic signed [35:0] LIM = 36'sd1 <<< COS_FRAC_BITS;
  always_comb begin
    c = xs[CORDIC_STEPS] >>> (32 - COS_FRAC_BITS);
    if (c > LIM) c = LIM;
    if (c < -LIM) c = -LIM;
    if (flips[CORDIC_STEPS]) c = -c;
    cos_val = (COS_FRAC_BITS+2)'(c);
  end
endmodule

// ----- design/itf_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, capped at 2^48.
module itf_divider import itf_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic [127:0] num,
  input  logic [63:0] den,
  output logic [48:0] quot,
  output logic ovf
);
  // Quotients of 2^48 and above only show as a cap, decided up front.
  logic [127:0] rems [DIV_STEPS+1];
  logic [63:0] dens [DIV_STEPS+1];
  logic [48:0] qs [DIV_STEPS+1];
  logic big [DIV_STEPS+1];

  // Stage zero: the high part num>>48 compared against den decides the cap.
  always_ff @(posedge clk) begin
    if (en) begin
      dens[0] <= den;
      rems[0] <= num;
      qs[0] <= '0;
      big[0] <= (den == 64'd0) ? (num != 128'd0) : ((num >> 48) >= {64'd0, den});
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    localparam int B = 48 - i;
    logic [127:0] trial;
    logic fits;
    always_comb begin
      trial = {64'd0, dens[i]} << B;
      fits = (dens[i] != 64'd0) && ((rems[i] >> B) >= {64'd0, dens[i]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dens[i+1] <= dens[i];
        big[i+1] <= big[i];
        rems[i+1] <= fits ? rems[i] - trial : rems[i];
        qs[i+1] <= {qs[i][47:0], fits};
      end
    end
  end

  assign quot = big[DIV_STEPS] ? 49'h1_0000_0000_0000 : qs[DIV_STEPS];
  assign ovf = big[DIV_STEPS] | (dens[DIV_STEPS] == 64'd0);
endmodule

// ----- design/ion_trap_electric_field_sum_core.sv -----
// Path: an accepted item spends most of its way in the CORDIC chain and the
// 50-stage divider chain.
// Throughput: one item per cycle; all stages hold together while a result
// waits under out_stall.
// Reset: synchronous rst clears valid bits and loads register defaults
// (radius and length 1.0, all others zero).
`include "ion_trap_electric_field_sum_core_macros.svh"
module ion_trap_electric_field_sum_core import itf_pkg::*; #(
  parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int LAT = CORDIC_STEPS + 56;
  localparam cfg_t CFG_RESET = '{trap_radius: 32'd16777216, axial_length: 32'd16777216,
                                 default: '0};
  cfg_t cfg;
  logic en;
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_AXIAL_DC: cfg.axial_dc_voltage <= cfg_data;
        REG_QUAD_OFF: cfg.quad_dc_offset <= cfg_data;
        REG_RF_AMP:   cfg.rf_amplitude <= cfg_data;
        REG_RF_RATE:  cfg.rf_phase_rate <= cfg_data;
        REG_AC_AMP:   cfg.ac_amplitude <= cfg_data;
        REG_AC_RATE:  cfg.ac_phase_rate <= cfg_data;
        REG_RADIUS:   cfg.trap_radius <= cfg_data;
        REG_LENGTH:   cfg.axial_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the last stage is empty or being taken.
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end
  assign out_valid = vld[LAT-1];

  // Stage 1: phase products and position register.
  logic [31:0] rf_ph, ac_ph;
  logic signed [31:0] px1, py1;
  always_ff @(posedge clk) begin
    if (en) begin
      rf_ph <= 32'(cfg.rf_phase_rate * in_data.time_tick[31:0]);
      ac_ph <= 32'(cfg.ac_phase_rate * in_data.time_tick[31:0]);
      px1 <= in_data.pos_x;
      py1 <= in_data.pos_y;
    end
  end

  logic signed [COS_FRAC_BITS+1:0] rf_cos, ac_cos;
  itf_cordic #(.COS_FRAC_BITS(COS_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_rf (
    .clk(clk), .en(en), .phase(rf_ph), .cos_val(rf_cos));
  itf_cordic #(.COS_FRAC_BITS(COS_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_ac (
    .clk(clk), .en(en), .phase(ac_ph), .cos_val(ac_cos));

  logic signed [31:0] pxd [CORDIC_STEPS+1];
  logic signed [31:0] pyd [CORDIC_STEPS+1];
  assign pxd[0] = px1;
  assign pyd[0] = py1;
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pd
    always_ff @(posedge clk) if (en) begin
      pxd[i+1] <= pxd[i];
      pyd[i+1] <= pyd[i];
    end
  end

  // Stage A: amplitude times cosine magnitudes, radius squared.
  logic [63:0] rf_pm, ac_pm, r2;
  logic rf_pneg, ac_pneg;
  logic signed [31:0] pxa, pya;
  always_ff @(posedge clk) if (en) begin
    rf_pm <= 64'(({32'd0, (cfg.rf_amplitude < 0) ? 32'(-cfg.rf_amplitude) : cfg.rf_amplitude}
              * 64'((rf_cos < 0) ? -rf_cos : rf_cos)) >> COS_FRAC_BITS);
    ac_pm <= 64'(({32'd0, (cfg.ac_amplitude < 0) ? 32'(-cfg.ac_amplitude) : cfg.ac_amplitude}
              * 64'((ac_cos < 0) ? -ac_cos : ac_cos)) >> COS_FRAC_BITS);
    rf_pneg <= (cfg.rf_amplitude < 0) != (rf_cos < 0);
    ac_pneg <= (cfg.ac_amplitude < 0) != (ac_cos < 0);
    r2 <= 64'(cfg.trap_radius) * 64'(cfg.trap_radius);
    pxa <= pxd[CORDIC_STEPS];
    pya <= pyd[CORDIC_STEPS];
  end

  // Stage B: s = offset + signed product.
  logic signed [64:0] s;
  logic [63:0] smag, ac_pmb, r2b;
  logic [31:0] axm, aym;
  logic sneg, pxn, pyn, ac_pnb;
  always_comb begin
    s = 65'(cfg.quad_dc_offset) + (rf_pneg ? -65'(rf_pm) : 65'(rf_pm));
  end
  always_ff @(posedge clk) if (en) begin
    smag <= 64'((s < 0) ? -s : s);
    sneg <= s < 0;
    axm <= (pxa < 0) ? 32'(-pxa) : pxa;
    aym <= (pya < 0) ? 32'(-pya) : pya;
    pxn <= pxa < 0;
    pyn <= pya < 0;
    ac_pmb <= ac_pm;
    ac_pnb <= ac_pneg;
    r2b <= r2;
  end

  // Stage C: 32 by 32 partial products of the position and s magnitudes.
  logic [63:0] xlo, xhi, ylo, yhi, ac_pmc, r2c;
  logic sx_neg, sy_neg, ac_neg, dc_neg;
  always_ff @(posedge clk) if (en) begin
    xlo <= {32'd0, axm} * {32'd0, smag[31:0]};
    xhi <= {32'd0, axm} * {32'd0, smag[63:32]};
    ylo <= {32'd0, aym} * {32'd0, smag[31:0]};
    yhi <= {32'd0, aym} * {32'd0, smag[63:32]};
    ac_pmc <= ac_pmb;
    sx_neg <= pxn != sneg;
    sy_neg <= pyn == sneg;
    ac_neg <= !ac_pnb;
    dc_neg <= cfg.axial_dc_voltage < 0;
    r2c <= r2b;
  end

  // Stage D: numerators.
  logic [31:0] dc_mag;
  logic [127:0] nx, ny, nac, ndc;
  logic [63:0] r2d;
  assign dc_mag = (cfg.axial_dc_voltage < 0) ? 32'(-cfg.axial_dc_voltage)
                                             : cfg.axial_dc_voltage;
  always_ff @(posedge clk) if (en) begin
    nx <= ((128'(xhi) << 32) + 128'(xlo)) << 25;
    ny <= ((128'(yhi) << 32) + 128'(ylo)) << 25;
    nac <= 128'(ac_pmc) << 24;
    ndc <= {96'd0, dc_mag} << 24;
    r2d <= r2c;
  end

  logic [48:0] qx, qy, qac, qdc;
  logic ox, oy, oac, odc;
  itf_divider u_dx (.clk(clk), .en(en), .num(nx), .den(r2d), .quot(qx), .ovf(ox));
  itf_divider u_dy (.clk(clk), .en(en), .num(ny), .den(r2d), .quot(qy), .ovf(oy));
  itf_divider u_dac (.clk(clk), .en(en), .num(nac), .den(64'(cfg.trap_radius)),
                     .quot(qac), .ovf(oac));
  itf_divider u_ddc (.clk(clk), .en(en), .num(ndc), .den(64'(cfg.axial_length)),
                     .quot(qdc), .ovf(odc));

  // Signs ride along through stage D and the divider chain.
  logic [3:0] sg [DIV_STEPS+3];
  assign sg[0] = {sx_neg, sy_neg, ac_neg, dc_neg};
  for (genvar i = 0; i < DIV_STEPS + 2; i++) begin : g_sg
    always_ff @(posedge clk) if (en) sg[i+1] <= sg[i];
  end

  // Final stage: sum enabled terms and saturate.
  logic rf_on, ac_on, dc_on;
  logic signed [51:0] ex, ey, ez;
  logic ov;
  localparam logic signed [51:0] MAX48 = 52'sd140737488355327;
  localparam logic signed [51:0] MIN48 = -52'sd140737488355328;
  assign rf_on = cfg.rf_amplitude != 0;
  assign ac_on = cfg.ac_amplitude != 0;
  assign dc_on = cfg.axial_dc_voltage != 0;
  always_comb begin
    ex = '0; ey = '0; ez = '0; ov = 1'b0;
    if (rf_on) begin
      ex = sg[DIV_STEPS+2][3] ? -52'(qx) : 52'(qx);
      ey = sg[DIV_STEPS+2][2] ? -52'(qy) : 52'(qy);
      ov = ox | oy;
    end
    if (ac_on) begin
      ex = ex + (sg[DIV_STEPS+2][1] ? -52'(qac) : 52'(qac));
      ov = ov | oac;
    end
    if (dc_on) begin
      ez = sg[DIV_STEPS+2][0] ? -52'(qdc) : 52'(qdc);
      ov = ov | odc;
    end
    if (ex > MAX48) begin ex = MAX48; ov = 1'b1; end
    if (ex < MIN48) begin ex = MIN48; ov = 1'b1; end
    if (ey > MAX48) begin ey = MAX48; ov = 1'b1; end
    if (ey < MIN48) begin ey = MIN48; ov = 1'b1; end
    if (ez > MAX48) begin ez = MAX48; ov = 1'b1; end
    if (ez < MIN48) begin ez = MIN48; ov = 1'b1; end
  end
  always_ff @(posedge clk) if (en) begin
    out_data.field_x <= 48'(ex);
    out_data.field_y <= 48'(ey);
    out_data.field_z <= 48'(ez);
    out_data.overflow <= ov;
  end

  `ITF_ASSERT_IMPL(a_stall_hold, out_valid && out_stall, in_stall, "input not stalled")
  `ITF_ASSERT_NEXT(a_valid_hold, out_valid && out_stall, out_valid, "result lost")
  `ITF_ASSERT_NEXT(a_data_hold, out_valid && out_stall, $stable(out_data), "result changed")
endmodule
